@@ rtl/spm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spm_pkg
// Shared sizes, action codes and RAM request type of the posting list merge.
// ----------------------------------------------------------------------------
package spm_pkg;

    // Capacity of each list and kept payload width
    localparam int LIST_DEPTH   = 32;
    localparam int PAYLOAD_BITS = 32;

    // Fixed field widths of the stream channels
    localparam int ID_W    = 32;
    localparam int PAY_W   = 32;
    localparam int DATA_W  = ID_W + PAY_W;
    localparam int USER_IN_W  = 2;
    localparam int USER_OUT_W = 2;

    // Stored entry: id in the low bits, payload above
    localparam int ENTRY_W = ID_W + PAYLOAD_BITS;
    localparam int ADDR_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LIST_DEPTH);

    // Action codes carried on s_tuser
    localparam logic [USER_IN_W-1:0] ACT_OLDER = 2'd0;
    localparam logic [USER_IN_W-1:0] ACT_NEWER = 2'd1;
    localparam logic [USER_IN_W-1:0] ACT_MERGE = 2'd2;

    // Request from the merge engine to one list RAM
    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        logic [ENTRY_W-1:0]  wdata;
        logic [ADDR_W-1:0]   raddr;
    } ram_req_t;

endpackage
`default_nettype wire

@@ rtl/spm_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module spm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                                     aclk,
    input  wire                                     we,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire [WIDTH-1:0]                         wdata,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/spm_merge_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spm_merge_engine
// Load and merge control: fills both list RAMs, then walks them in order of
// document id and drives the registered result stage.
// ----------------------------------------------------------------------------
module spm_merge_engine (
    input  wire                               aclk,
    input  wire                               aresetn,
    // input transactions
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire [spm_pkg::DATA_W-1:0]         s_tdata,
    input  wire [spm_pkg::USER_IN_W-1:0]      s_tuser,
    // result transactions
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [spm_pkg::DATA_W-1:0]        m_tdata,
    output logic                              m_tlast,
    output logic [spm_pkg::USER_OUT_W-1:0]    m_tuser,
    // list RAM ports
    output spm_pkg::ram_req_t                 older_req,
    output spm_pkg::ram_req_t                 newer_req,
    input  wire [spm_pkg::ENTRY_W-1:0]        older_rdata,
    input  wire [spm_pkg::ENTRY_W-1:0]        newer_rdata
);
    import spm_pkg::*;

    typedef enum logic {ST_IDLE, ST_MERGE} state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_o_reg, cnt_o_next;
    logic [CNT_W-1:0]    cnt_n_reg, cnt_n_next;
    logic [CNT_W-1:0]    ptr_o_reg, ptr_o_next;
    logic [CNT_W-1:0]    ptr_n_reg, ptr_n_next;
    logic                dropped_reg, dropped_next;
    logic                m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]   m_data_reg, m_data_next;
    logic                m_last_reg, m_last_next;
    logic [USER_OUT_W-1:0] m_user_reg, m_user_next;

    logic [ID_W-1:0]     id_o, id_n;
    logic                o_left, n_left;
    logic                take_o, take_n, adv_o, adv_n;
    logic [CNT_W-1:0]    ptr_o_adv, ptr_n_adv;
    logic                is_last, emit;
    logic [ENTRY_W-1:0]  load_entry;
    logic [ENTRY_W-1:0]  sel_entry;

    // Heads of both lists come straight from the RAM read registers
    assign id_o   = older_rdata[ID_W-1:0];
    assign id_n   = newer_rdata[ID_W-1:0];
    assign o_left = ptr_o_reg < cnt_o_reg;
    assign n_left = ptr_n_reg < cnt_n_reg;

    // Pick the smaller id; a tie takes the newer posting and skips the older
    assign take_o    = o_left && (!n_left || (id_o < id_n));
    assign take_n    = n_left && (!o_left || (id_n <= id_o));
    assign adv_o     = take_o || (o_left && n_left && (id_o == id_n));
    assign adv_n     = take_n;
    assign ptr_o_adv = ptr_o_reg + CNT_W'(adv_o);
    assign ptr_n_adv = ptr_n_reg + CNT_W'(adv_n);
    assign is_last   = !(ptr_o_adv < cnt_o_reg) && !(ptr_n_adv < cnt_n_reg);
    assign sel_entry = take_n ? newer_rdata : older_rdata;
    assign emit      = (state_reg == ST_MERGE) && (!m_valid_reg || m_tready);

    assign load_entry = {s_tdata[ID_W +: PAYLOAD_BITS], s_tdata[ID_W-1:0]};

    // Next-state logic
    always_comb begin
        state_next   = state_reg;
        cnt_o_next   = cnt_o_reg;
        cnt_n_next   = cnt_n_reg;
        ptr_o_next   = ptr_o_reg;
        ptr_n_next   = ptr_n_reg;
        dropped_next = dropped_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_user_next  = m_user_reg;
        s_tready     = 1'b0;

        older_req.we    = 1'b0;
        older_req.waddr = cnt_o_reg[ADDR_W-1:0];
        older_req.wdata = load_entry;
        newer_req.we    = 1'b0;
        newer_req.waddr = cnt_n_reg[ADDR_W-1:0];
        newer_req.wdata = load_entry;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (s_tuser)
                        ACT_OLDER: begin
                            if (cnt_o_reg < DEPTH_CNT) begin
                                older_req.we = 1'b1;
                                cnt_o_next   = cnt_o_reg + CNT_W'(1);
                            end else begin
                                dropped_next = 1'b1;
                            end
                        end
                        ACT_NEWER: begin
                            if (cnt_n_reg < DEPTH_CNT) begin
                                newer_req.we = 1'b1;
                                cnt_n_next   = cnt_n_reg + CNT_W'(1);
                            end else begin
                                dropped_next = 1'b1;
                            end
                        end
                        ACT_MERGE: begin
                            if ((cnt_o_reg == '0) && (cnt_n_reg == '0)) begin
                                dropped_next = 1'b0;
                            end else begin
                                state_next = ST_MERGE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MERGE: begin
                if (emit) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {PAY_W'(sel_entry[ENTRY_W-1:ID_W]),
                                    sel_entry[ID_W-1:0]};
                    m_last_next  = is_last;
                    m_user_next  = {dropped_reg, take_n};
                    ptr_o_next   = ptr_o_adv;
                    ptr_n_next   = ptr_n_adv;
                    if (is_last) begin
                        state_next   = ST_IDLE;
                        cnt_o_next   = '0;
                        cnt_n_next   = '0;
                        ptr_o_next   = '0;
                        ptr_n_next   = '0;
                        dropped_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Read at the pointer the next cycle will hold, so data lines up
        older_req.raddr = ptr_o_next[ADDR_W-1:0];
        newer_req.raddr = ptr_n_next[ADDR_W-1:0];
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_o_reg   <= '0;
            cnt_n_reg   <= '0;
            ptr_o_reg   <= '0;
            ptr_n_reg   <= '0;
            dropped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_o_reg   <= cnt_o_next;
            cnt_n_reg   <= cnt_n_next;
            ptr_o_reg   <= ptr_o_next;
            ptr_n_reg   <= ptr_n_next;
            dropped_reg <= dropped_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule
`default_nettype wire

@@ rtl/sorted_posting_list_merge.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_posting_list_merge
// Merges an older and a newer posting list, each sorted by document id.
//
// Usage: each s_ transaction carries an action on s_tuser. Action older or
// newer appends {payload, doc_id} from s_tdata to that list; an append to
// a full list is dropped and sets the overflow flag. Action merge emits the
// held postings on the m_ channel in order of document id, one result per
// cycle while m_tready is high, m_tlast on the final one; on equal ids the
// newer posting wins and the older one is skipped. m_tvalid rises once the
// merge state is entered and the result register is loaded. m_tuser[0]
// flags a newer posting and m_tuser[1] shows overflow. Both lists and the
// flag clear after a merge; a merge of two empty lists emits nothing.
// Loads are taken back to back while idle; a merge walks the two list RAMs
// in step with the results it emits. s_tready is low while a merge runs.
// When the receiver stalls, the result register holds and the walk pauses
// with it. Reset empties both lists, clears overflow and drops any pending
// result; RAM contents are not cleared since only filled entries are read.
// ----------------------------------------------------------------------------
module sorted_posting_list_merge (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // s_tdata: doc_id [31:0], payload [63:32]
    input  wire [spm_pkg::DATA_W-1:0]         s_tdata,
    // s_tuser: action [1:0]
    input  wire [spm_pkg::USER_IN_W-1:0]      s_tuser,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // m_tdata: doc_id_res [31:0], payload_res [63:32]
    output logic [spm_pkg::DATA_W-1:0]        m_tdata,
    output logic                              m_tlast,
    // m_tuser: from_newer [0], overflow [1]
    output logic [spm_pkg::USER_OUT_W-1:0]    m_tuser
);
    import spm_pkg::*;

    ram_req_t            older_req, newer_req;
    logic [ENTRY_W-1:0]  older_rdata, newer_rdata;

    // Control and result stage
    spm_merge_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .older_req   (older_req),
        .newer_req   (newer_req),
        .older_rdata (older_rdata),
        .newer_rdata (newer_rdata)
    );

    // Older list storage
    spm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LIST_DEPTH)
    ) u_older_ram (
        .aclk  (aclk),
        .we    (older_req.we),
        .waddr (older_req.waddr),
        .wdata (older_req.wdata),
        .raddr (older_req.raddr),
        .rdata (older_rdata)
    );

    // Newer list storage
    spm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LIST_DEPTH)
    ) u_newer_ram (
        .aclk  (aclk),
        .we    (newer_req.we),
        .waddr (newer_req.waddr),
        .wdata (newer_req.wdata),
        .raddr (newer_req.raddr),
        .rdata (newer_rdata)
    );

endmodule
`default_nettype wire
